@@ rtl/core/mat3_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mat3_pkg
// Shared types, command codes and the microcode program of the 3x3 matrix
// arithmetic unit.
// ----------------------------------------------------------------------------
package mat3_pkg;

   // Element storage width
   localparam int ELEM_WIDTH = 16;

   // Fixed field widths of the transaction ports
   localparam int CMD_W   = 3;
   localparam int INDEX_W = 4;
   localparam int VALUE_W = 16;
   localparam int RES_W   = 49;

   // Matrix shape
   localparam int MAT_DIM   = 3;
   localparam int MAT_DEPTH = MAT_DIM * MAT_DIM;

   // Product register: wide enough for a triple product of elements
   localparam int PROD_W = 3 * ELEM_WIDTH;
   localparam int WIDE_W = 2 * ELEM_WIDTH;

   typedef logic [CMD_W-1:0]             cmd_type;
   typedef logic [INDEX_W-1:0]           idx_type;
   typedef logic signed [VALUE_W-1:0]    value_type;
   typedef logic signed [RES_W-1:0]      res_type;
   typedef logic signed [ELEM_WIDTH-1:0] elem_type;
   typedef logic signed [WIDE_W-1:0]     wide_type;
   typedef logic signed [PROD_W-1:0]     prod_type;

   localparam idx_type MAX_INDEX = idx_type'(MAT_DEPTH - 1);

   // Command codes
   localparam cmd_type CMD_LOAD_FIRST  = 3'd0;
   localparam cmd_type CMD_LOAD_SECOND = 3'd1;
   localparam cmd_type CMD_ADD         = 3'd2;
   localparam cmd_type CMD_SUB         = 3'd3;
   localparam cmd_type CMD_MUL         = 3'd4;
   localparam cmd_type CMD_TRANSPOSE   = 3'd5;
   localparam cmd_type CMD_SINGULAR    = 3'd6;

   // Accumulator operations
   typedef logic [2:0] acc_op_type;
   localparam acc_op_type ACC_HOLD = 3'd0;
   localparam acc_op_type ACC_SUM  = 3'd1;
   localparam acc_op_type ACC_DIFF = 3'd2;
   localparam acc_op_type ACC_X    = 3'd3;
   localparam acc_op_type ACC_LDP  = 3'd4;
   localparam acc_op_type ACC_ADDP = 3'd5;
   localparam acc_op_type ACC_SUBP = 3'd6;

   // Branch control
   typedef logic [1:0] br_type;
   localparam br_type BR_NEXT     = 2'd0;
   localparam br_type BR_DISPATCH = 2'd1;
   localparam br_type BR_DONE     = 2'd2;

   // Program layout
   localparam int ELEMWISE_LEN = MAT_DEPTH + 1;
   localparam int MUL_LEN      = MAT_DEPTH * MAT_DIM + 2;
   localparam int DET_TERMS    = 6;
   localparam int DET_LEN      = DET_TERMS * 3 + 1;
   localparam int S_ADD        = 1;
   localparam int S_SUB        = S_ADD + ELEMWISE_LEN;
   localparam int S_TRN        = S_SUB + ELEMWISE_LEN;
   localparam int S_MUL        = S_TRN + ELEMWISE_LEN;
   localparam int S_DET        = S_MUL + MUL_LEN;
   localparam int UC_DEPTH     = S_DET + DET_LEN;
   localparam int PC_W         = $clog2(UC_DEPTH);

   typedef logic [PC_W-1:0] pc_type;

   localparam pc_type PC_IDLE = pc_type'(0);

   // One control word per step
   typedef struct packed {
      idx_type    ax;        // first matrix read address, x operand
      idx_type    ay;        // read address, y operand
      logic       y_from_b;  // y operand from second matrix
      logic       mul_py;    // product = product * y, else x * y
      acc_op_type acc_op;
      logic       emit;      // push accumulator input to the result register
      logic       last;
      logic       zflag;     // flag a zero result as singular
      idx_type    res_idx;
      br_type     br;
   } ctrl_word_type;

   typedef ctrl_word_type [UC_DEPTH-1:0] ucode_type;

   // Memory write request from the input side
   typedef struct packed {
      logic     first_en;
      logic     second_en;
      idx_type  idx;
      elem_type value;
   } wr_req_type;

   typedef struct packed {
      idx_type i;
      idx_type j;
      idx_type l;
      logic    neg;
   } det_term_type;

   // Cofactor expansion along the first row as six signed triple products
   function automatic det_term_type det_term(input int t);
      det_term_type d;
      unique case (t)
         0:       d = '{i: 4'd0, j: 4'd4, l: 4'd8, neg: 1'b0};
         1:       d = '{i: 4'd0, j: 4'd5, l: 4'd7, neg: 1'b1};
         2:       d = '{i: 4'd1, j: 4'd3, l: 4'd8, neg: 1'b1};
         3:       d = '{i: 4'd1, j: 4'd5, l: 4'd6, neg: 1'b0};
         4:       d = '{i: 4'd2, j: 4'd3, l: 4'd7, neg: 1'b0};
         default: d = '{i: 4'd2, j: 4'd4, l: 4'd6, neg: 1'b1};
      endcase
      return d;
   endfunction

   function automatic ucode_type build_ucode();
      ucode_type    rom;
      det_term_type d;
      int           p;
      int           j;
      int           k;
      int           r;
      int           c;
      int           t;
      int           w;
      rom = '0;
      rom[0].br = BR_DISPATCH;

      // Element-wise programs: read at step p, combine and emit at step p+1
      for (p = 0; p < MAT_DEPTH; p++) begin
         r = p / MAT_DIM;
         c = p % MAT_DIM;
         rom[S_ADD + p].ax       = idx_type'(p);
         rom[S_ADD + p].ay       = idx_type'(p);
         rom[S_ADD + p].y_from_b = 1'b1;
         rom[S_ADD + p + 1].acc_op  = ACC_SUM;
         rom[S_ADD + p + 1].emit    = 1'b1;
         rom[S_ADD + p + 1].res_idx = idx_type'(p);
         rom[S_ADD + p + 1].last    = (p == MAT_DEPTH - 1);

         rom[S_SUB + p].ax       = idx_type'(p);
         rom[S_SUB + p].ay       = idx_type'(p);
         rom[S_SUB + p].y_from_b = 1'b1;
         rom[S_SUB + p + 1].acc_op  = ACC_DIFF;
         rom[S_SUB + p + 1].emit    = 1'b1;
         rom[S_SUB + p + 1].res_idx = idx_type'(p);
         rom[S_SUB + p + 1].last    = (p == MAT_DEPTH - 1);

         rom[S_TRN + p].ax = idx_type'(c * MAT_DIM + r);
         rom[S_TRN + p + 1].acc_op  = ACC_X;
         rom[S_TRN + p + 1].emit    = 1'b1;
         rom[S_TRN + p + 1].res_idx = idx_type'(p);
         rom[S_TRN + p + 1].last    = (p == MAT_DEPTH - 1);
      end
      rom[S_ADD + MAT_DEPTH].br = BR_DONE;
      rom[S_SUB + MAT_DEPTH].br = BR_DONE;
      rom[S_TRN + MAT_DEPTH].br = BR_DONE;

      // Multiply: read at j, multiply at j+1, accumulate at j+2
      for (j = 0; j < MAT_DEPTH * MAT_DIM; j++) begin
         p = j / MAT_DIM;
         k = j % MAT_DIM;
         r = p / MAT_DIM;
         c = p % MAT_DIM;
         rom[S_MUL + j].ax       = idx_type'(r * MAT_DIM + k);
         rom[S_MUL + j].ay       = idx_type'(k * MAT_DIM + c);
         rom[S_MUL + j].y_from_b = 1'b1;
         rom[S_MUL + j + 2].acc_op = (k == 0) ? ACC_LDP : ACC_ADDP;
         if (k == MAT_DIM - 1) begin
            rom[S_MUL + j + 2].emit    = 1'b1;
            rom[S_MUL + j + 2].res_idx = idx_type'(p);
            rom[S_MUL + j + 2].last    = (p == MAT_DEPTH - 1);
         end
      end
      rom[S_MUL + MUL_LEN - 1].br = BR_DONE;

      // Determinant: each term reads a pair, then the third element,
      // multiplies twice, then accumulates the triple product
      for (t = 0; t < DET_TERMS; t++) begin
         d = det_term(t);
         w = S_DET + 3 * t;
         rom[w].ax     = d.i;
         rom[w].ay     = d.j;
         rom[w + 1].ay = d.l;
         rom[w + 2].mul_py = 1'b1;
         if (t == 0) begin
            rom[w + 3].acc_op = ACC_LDP;
         end else begin
            rom[w + 3].acc_op = d.neg ? ACC_SUBP : ACC_ADDP;
         end
      end
      rom[UC_DEPTH - 1].emit  = 1'b1;
      rom[UC_DEPTH - 1].last  = 1'b1;
      rom[UC_DEPTH - 1].zflag = 1'b1;
      rom[UC_DEPTH - 1].br    = BR_DONE;
      return rom;
   endfunction

   localparam ucode_type UCODE = build_ucode();

endpackage : mat3_pkg
`default_nettype wire

@@ rtl/core/mat3_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mat3_sequencer
// Step counter over the microcode table, with command dispatch from idle.
// ----------------------------------------------------------------------------
module mat3_sequencer (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     adv,
   input  wire                     req_valid,
   input  mat3_pkg::cmd_type       req_cmd,
   output mat3_pkg::ctrl_word_type ctrl,
   output logic                    idle
);
   import mat3_pkg::*;

   pc_type pc_ff;
   pc_type pc_in;
   pc_type entry;

   assign ctrl = UCODE[pc_ff];
   assign idle = (pc_ff == PC_IDLE);

   always_comb begin
      unique case (req_cmd)
         CMD_ADD:       entry = pc_type'(S_ADD);
         CMD_SUB:       entry = pc_type'(S_SUB);
         CMD_MUL:       entry = pc_type'(S_MUL);
         CMD_TRANSPOSE: entry = pc_type'(S_TRN);
         CMD_SINGULAR:  entry = pc_type'(S_DET);
         default:       entry = PC_IDLE;
      endcase
   end

   always_comb begin
      pc_in = pc_ff;
      if (adv) begin
         unique case (ctrl.br)
            BR_NEXT:     pc_in = pc_type'(pc_ff + 1'b1);
            BR_DISPATCH: pc_in = req_valid ? entry : PC_IDLE;
            BR_DONE:     pc_in = PC_IDLE;
            default:     pc_in = PC_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule : mat3_sequencer
`default_nettype wire

@@ rtl/core/mat3_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mat3_datapath
// Matrix stores, operand registers, shared multiplier, accumulator and the
// result register.
// ----------------------------------------------------------------------------
module mat3_datapath (
   input  wire                     clock,
   input  wire                     reset,
   input  mat3_pkg::ctrl_word_type ctrl,
   input  mat3_pkg::wr_req_type    wr,
   output logic                    adv,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output mat3_pkg::res_type       rsp_result_value,
   output mat3_pkg::idx_type       rsp_result_index,
   output logic                    rsp_last_result,
   output logic                    rsp_det_zero
);
   import mat3_pkg::*;

   elem_type first_mem_ff  [MAT_DEPTH];
   elem_type second_mem_ff [MAT_DEPTH];

   elem_type opx_ff;
   elem_type opy_ff;
   prod_type prod_ff;
   prod_type prod_in;
   wide_type prod_lo;
   res_type  acc_ff;
   res_type  acc_in;

   logic     rsp_valid_ff;
   res_type  rsp_value_ff;
   idx_type  rsp_index_ff;
   logic     rsp_last_ff;
   logic     rsp_sing_ff;

   // Freeze the whole datapath while a result cannot be handed over
   assign adv = !(ctrl.emit && rsp_valid_ff && rsp_stall);

   // Matrix stores: written from idle loads, read into the operand registers
   always_ff @(posedge clock) begin
      if (wr.first_en) begin
         first_mem_ff[wr.idx] <= wr.value;
      end
      if (wr.second_en) begin
         second_mem_ff[wr.idx] <= wr.value;
      end
      if (adv) begin
         opx_ff <= first_mem_ff[ctrl.ax];
         opy_ff <= ctrl.y_from_b ? second_mem_ff[ctrl.ay] : first_mem_ff[ctrl.ay];
      end
   end

   assign prod_lo = prod_ff[WIDE_W-1:0];

   always_comb begin
      if (ctrl.mul_py) begin
         prod_in = prod_type'(prod_lo) * prod_type'(opy_ff);
      end else begin
         prod_in = prod_type'(wide_type'(opx_ff) * wide_type'(opy_ff));
      end
   end

   always_comb begin
      unique case (ctrl.acc_op)
         ACC_HOLD: acc_in = acc_ff;
         ACC_SUM:  acc_in = res_type'(opx_ff) + res_type'(opy_ff);
         ACC_DIFF: acc_in = res_type'(opx_ff) - res_type'(opy_ff);
         ACC_X:    acc_in = res_type'(opx_ff);
         ACC_LDP:  acc_in = res_type'(prod_ff);
         ACC_ADDP: acc_in = acc_ff + res_type'(prod_ff);
         ACC_SUBP: acc_in = acc_ff - res_type'(prod_ff);
         default:  acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
         acc_ff  <= acc_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.emit && adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit && adv) begin
         rsp_value_ff <= acc_in;
         rsp_index_ff <= ctrl.res_idx;
         rsp_last_ff  <= ctrl.last;
         rsp_sing_ff  <= ctrl.zflag && (acc_in == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_last_result  = rsp_last_ff;
   assign rsp_det_zero     = rsp_sing_ff;

endmodule : mat3_datapath
`default_nettype wire

@@ rtl/core/matrix_3x3_arith_unit_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_3x3_arith_unit_top
// 3x3 matrix arithmetic unit: two stored matrices, element loads, add,
// subtract, multiply, transpose and determinant with a singular flag.
// ----------------------------------------------------------------------------
// The unit holds two 3x3 matrices of signed elements in row-major order. A
// load transaction (command load first or load second) writes one element
// and produces no result; an index above eight is dropped. Add, subtract,
// multiply and transpose each produce nine result transactions in row-major
// order with the ninth flagged as last; the singular command produces one
// result carrying the determinant of the first matrix, flagged last and
// flagged singular when it is zero. Results are exact to 49 bits. Read only
// elements that have been loaded: an element never written returns whatever
// the store holds. One command is worked on at a time, under a microcoded
// sequencer that steps through a fixed program for each compute command; a
// load or an unused code is done in the dispatch step itself. Programs are
// paced by one read per operand store and one shared multiplier per cycle,
// but a program holds at a result step while the previous result still
// waits on a stalled result channel.
// ----------------------------------------------------------------------------
module matrix_3x3_arith_unit_top (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  mat3_pkg::cmd_type   req_cmd,
   input  mat3_pkg::idx_type   req_elem_index,
   input  mat3_pkg::value_type req_elem_value,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output mat3_pkg::res_type   rsp_result_value,
   output mat3_pkg::idx_type   rsp_result_index,
   output logic                rsp_last_result,
   output logic                rsp_det_zero
);
   import mat3_pkg::*;

   ctrl_word_type ctrl;
   wr_req_type    wr;
   logic          idle;
   logic          adv;
   logic          req_accept;
   logic          idx_ok;

   // Take a transaction only while the sequencer waits in its dispatch step
   assign req_stall  = !idle;
   assign req_accept = req_valid && !req_stall;
   assign idx_ok     = (req_elem_index <= MAX_INDEX);

   // Loads go straight into the stores; drop an out-of-range index
   assign wr.first_en  = req_accept && (req_cmd == CMD_LOAD_FIRST) && idx_ok;
   assign wr.second_en = req_accept && (req_cmd == CMD_LOAD_SECOND) && idx_ok;
   assign wr.idx       = req_elem_index;
   assign wr.value     = elem_type'(req_elem_value);

   mat3_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .ctrl      (ctrl),
      .idle      (idle)
   );

   mat3_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .wr               (wr),
      .adv              (adv),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_result_index (rsp_result_index),
      .rsp_last_result  (rsp_last_result),
      .rsp_det_zero     (rsp_det_zero)
   );

   // A compute command must leave the dispatch step
   a_compute_starts : assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_cmd == CMD_ADD || req_cmd == CMD_SUB || req_cmd == CMD_MUL
         || req_cmd == CMD_TRANSPOSE || req_cmd == CMD_SINGULAR)) |=> !idle)
      else $error("compute transaction did not start the program");

   // The last result handed over ends the program
   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      (ctrl.emit && ctrl.last && adv) |=> idle)
      else $error("program continued after its last result");

   // A blocked step holds its control word
   a_hold_step : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(ctrl))
      else $error("control word moved while a result was blocked");

   // The singular flag only comes with the single determinant result
   a_singular_shape : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_det_zero) |-> (rsp_last_result && rsp_result_index == '0))
      else $error("singular flag on a matrix element result");

endmodule : matrix_3x3_arith_unit_top
`default_nettype wire

@@ bench/tb_matrix_3x3_arith_unit_top.sv @@
// ----------------------------------------------------------------------------
// tb_matrix_3x3_arith_unit_top
// Self-checking bench for the 3x3 matrix arithmetic unit. A queue of command
// transactions (element loads, add, subtract, multiply, transpose, singular)
// feeds a falling-edge driver; every accepted command is run through a local
// copy of both matrices to build the result transactions it should produce,
// and a rising-edge monitor checks each returned result field by field.
// ----------------------------------------------------------------------------
module tb_matrix_3x3_arith_unit_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mat3_pkg::*;

   // Code the block leaves unused: accepted, produces nothing
   localparam cmd_type CMD_UNUSED = 3'd7;

   localparam int RANDOM_ITEMS = 290;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;    // outlasts the multiply program, the longest

   typedef struct {
      cmd_type   cmd;
      idx_type   idx;
      value_type value;
   } mat_command_type;

   typedef struct {
      res_type value;
      idx_type index;
      logic    last;
      logic    singular;
   } mat_result_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   cmd_type   req_cmd;
   idx_type   req_elem_index;
   value_type req_elem_value;
   logic      rsp_valid;
   logic      rsp_stall;
   res_type   rsp_result_value;
   idx_type   rsp_result_index;
   logic      rsp_last_result;
   logic      rsp_det_zero;

   // Commands waiting to be driven, and results waiting to be returned
   mat_command_type pending_cmds[$];
   mat_result_type  awaited_results[$];

   // Local copy of the two stored matrices
   elem_type first_elems[MAT_DEPTH];
   elem_type second_elems[MAT_DEPTH];

   int   item_total;
   int   accepted_count;
   int   mismatch_count;
   int   cycle_count;
   int   req_gap;
   int   stall_left;
   logic req_taken;
   logic idling_on;

   matrix_3x3_arith_unit_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_elem_index   (req_elem_index),
      .req_elem_value   (req_elem_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_result_index (rsp_result_index),
      .rsp_last_result  (rsp_last_result),
      .rsp_det_zero     (rsp_det_zero)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Matrix predictor: update the local store for loads, queue the results
   // that a compute command returns.
   // ------------------------------------------------------------------------
   task automatic apply_command(input cmd_type cmd, input idx_type idx,
                                input value_type value);
      elem_type       v;
      longint         a[MAT_DEPTH];
      longint         b[MAT_DEPTH];
      longint         x;
      longint         det;
      int             r;
      int             c;
      int             k;
      int             p;
      mat_result_type res;
      // Narrow stores keep the low bits, sign-extended; wide ones keep all
      v = elem_type'(value);
      for (p = 0; p < MAT_DEPTH; p++) begin
         a[p] = longint'(first_elems[p]);
         b[p] = longint'(second_elems[p]);
      end
      case (cmd)
         CMD_LOAD_FIRST: begin
            if (idx <= MAX_INDEX) first_elems[idx] = v;
         end
         CMD_LOAD_SECOND: begin
            if (idx <= MAX_INDEX) second_elems[idx] = v;
         end
         CMD_SINGULAR: begin
            // Cofactor expansion along the top row
            det = a[0] * (a[4] * a[8] - a[5] * a[7])
                - a[1] * (a[3] * a[8] - a[5] * a[6])
                + a[2] * (a[3] * a[7] - a[4] * a[6]);
            res.value    = res_type'(det);
            res.index    = '0;
            res.last     = 1'b1;
            res.singular = (det == 0);
            awaited_results.push_back(res);
         end
         CMD_ADD, CMD_SUB, CMD_MUL, CMD_TRANSPOSE: begin
            for (r = 0; r < MAT_DIM; r++) begin
               for (c = 0; c < MAT_DIM; c++) begin
                  p = r * MAT_DIM + c;
                  x = 0;
                  case (cmd)
                     CMD_ADD: x = a[p] + b[p];
                     CMD_SUB: x = a[p] - b[p];
                     CMD_MUL: begin
                        for (k = 0; k < MAT_DIM; k++)
                           x += a[r * MAT_DIM + k] * b[k * MAT_DIM + c];
                     end
                     default: x = a[c * MAT_DIM + r];
                  endcase
                  res.value    = res_type'(x);
                  res.index    = idx_type'(p);
                  res.last     = (p == MAT_DEPTH - 1);
                  res.singular = 1'b0;
                  awaited_results.push_back(res);
               end
            end
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic void queue_command(input cmd_type cmd, input idx_type idx,
                                         input value_type value);
      mat_command_type m;
      m.cmd   = cmd;
      m.idx   = idx;
      m.value = value;
      pending_cmds.push_back(m);
   endfunction

   // Mostly random 16-bit values, now and then an extreme
   function automatic value_type pick_value();
      int sel;
      sel = $urandom_range(0, 19);
      case (sel)
         0:       return value_type'(16'h8000);
         1:       return value_type'(16'h7fff);
         2:       return '0;
         3:       return '1;
         default: return value_type'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Acceptance: predict on every command transaction taken at a rising edge
   // and note it for the driver. Idling is switched off in quiet stretches
   // and over the closing part of the run.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         apply_command(req_cmd, req_elem_index, req_elem_value);
         req_taken = 1'b1;
         accepted_count++;
      end
      idling_on = (accepted_count + 40 < item_total) &&
                  (((accepted_count / 60) % 4) != 3);
   end

   // ------------------------------------------------------------------------
   // Command driver: hold a stalled transaction, otherwise insert a random
   // gap or present the next pending command.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_taken && idling_on && $urandom_range(0, 2) == 0)
            req_gap = $urandom_range(1, 11);
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() != 0) begin
            mat_command_type m;
            m = pending_cmds.pop_front();
            req_cmd        <= m.cmd;
            req_elem_index <= m.idx;
            req_elem_value <= m.value;
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_taken = 1'b0;
   end

   // Result back-pressure: random stall bursts while idling is on
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 11) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // Result monitor: compare each returned transaction with the oldest
   // awaited result.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("unexpected result: value %0d index %0d",
                   rsp_result_value, rsp_result_index);
            mismatch_count++;
         end else begin
            mat_result_type e;
            e = awaited_results.pop_front();
            if (rsp_result_value !== e.value) begin
               $error("result_value: expected %0d, got %0d", e.value, rsp_result_value);
               mismatch_count++;
            end
            if (rsp_result_index !== e.index) begin
               $error("result_index: expected %0d, got %0d", e.index, rsp_result_index);
               mismatch_count++;
            end
            if (rsp_last_result !== e.last) begin
               $error("last_result: expected %0b, got %0b", e.last, rsp_last_result);
               mismatch_count++;
            end
            if (rsp_det_zero !== e.singular) begin
               $error("det_zero: expected %0b, got %0b", e.singular, rsp_det_zero);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_matrix_3x3_arith_unit_top NOT OK");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int counted;
      int sel;
      int row;
      int col;
      value_type rv[MAT_DIM];

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_LOAD_FIRST;
      req_elem_index = '0;
      req_elem_value = '0;
      rsp_stall      = 1'b0;
      req_taken      = 1'b0;
      idling_on      = 1'b0;
      req_gap        = 0;
      stall_left     = 0;
      accepted_count = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      item_total     = 1 << 30;
      for (int i = 0; i < MAT_DEPTH; i++) begin
         first_elems[i]  = '0;
         second_elems[i] = '0;
      end

      // Directed part. Fill every entry of both matrices first, so that no
      // later command reads an unwritten entry. The top two rows of the first
      // matrix match, which makes it singular.
      queue_command(CMD_LOAD_FIRST, 4'd0, value_type'(16'h8000));
      queue_command(CMD_LOAD_FIRST, 4'd1, value_type'(16'h7fff));
      queue_command(CMD_LOAD_FIRST, 4'd2, value_type'(-1));
      queue_command(CMD_LOAD_FIRST, 4'd3, value_type'(16'h8000));
      queue_command(CMD_LOAD_FIRST, 4'd4, value_type'(16'h7fff));
      queue_command(CMD_LOAD_FIRST, 4'd5, value_type'(-1));
      queue_command(CMD_LOAD_FIRST, 4'd6, value_type'(0));
      queue_command(CMD_LOAD_FIRST, 4'd7, value_type'(1));
      queue_command(CMD_LOAD_FIRST, MAX_INDEX, value_type'(16'h8000));
      queue_command(CMD_LOAD_SECOND, 4'd0, value_type'(16'h7fff));
      queue_command(CMD_LOAD_SECOND, 4'd1, value_type'(16'h8000));
      queue_command(CMD_LOAD_SECOND, 4'd2, value_type'(1));
      queue_command(CMD_LOAD_SECOND, 4'd3, value_type'(-1));
      queue_command(CMD_LOAD_SECOND, 4'd4, value_type'(0));
      queue_command(CMD_LOAD_SECOND, 4'd5, value_type'(16'h7fff));
      queue_command(CMD_LOAD_SECOND, 4'd6, value_type'(16'h8000));
      queue_command(CMD_LOAD_SECOND, 4'd7, value_type'(16'h8000));
      queue_command(CMD_LOAD_SECOND, MAX_INDEX, value_type'(16'h8000));
      queue_command(CMD_ADD, '0, '0);
      queue_command(CMD_SUB, '0, '0);
      queue_command(CMD_MUL, '0, '0);
      queue_command(CMD_TRANSPOSE, '0, '0);
      queue_command(CMD_SINGULAR, '0, '0);
      // Out-of-range load and the unused code must leave the store alone
      queue_command(CMD_LOAD_FIRST, 4'd15, value_type'(16'h1234));
      queue_command(CMD_UNUSED, 4'd15, value_type'(16'hffff));
      // Break the matching rows: determinant no longer zero
      queue_command(CMD_LOAD_FIRST, 4'd4, value_type'(16'h8000));
      queue_command(CMD_SINGULAR, '0, '0);

      // Random part: mostly loads with random content and compute commands,
      // some deliberately singular set-ups, and a little noise.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 50) begin
            queue_command($urandom_range(0, 1) ? CMD_LOAD_SECOND : CMD_LOAD_FIRST,
                          idx_type'($urandom_range(0, MAT_DEPTH - 1)), pick_value());
            counted++;
         end else if (sel < 85) begin
            queue_command(cmd_type'($urandom_range(CMD_ADD, CMD_SINGULAR)),
                          idx_type'($urandom), value_type'($urandom));
            counted++;
         end else if (sel < 90) begin
            // Two equal rows, then ask for the determinant
            row = $urandom_range(0, MAT_DIM - 1);
            for (col = 0; col < MAT_DIM; col++) rv[col] = pick_value();
            for (col = 0; col < MAT_DIM; col++) begin
               queue_command(CMD_LOAD_FIRST, idx_type'(row * MAT_DIM + col), rv[col]);
               queue_command(CMD_LOAD_FIRST,
                             idx_type'(((row + 1) % MAT_DIM) * MAT_DIM + col), rv[col]);
            end
            queue_command(CMD_SINGULAR, '0, '0);
            counted += 7;
         end else if (sel < 93) begin
            // Zero column, then ask for the determinant
            col = $urandom_range(0, MAT_DIM - 1);
            for (row = 0; row < MAT_DIM; row++)
               queue_command(CMD_LOAD_FIRST, idx_type'(row * MAT_DIM + col), '0);
            queue_command(CMD_SINGULAR, '0, '0);
            counted += 4;
         end else if (sel < 97) begin
            queue_command($urandom_range(0, 1) ? CMD_LOAD_SECOND : CMD_LOAD_FIRST,
                          idx_type'($urandom_range(MAT_DEPTH, 15)), value_type'($urandom));
         end else begin
            queue_command(CMD_UNUSED, idx_type'($urandom), value_type'($urandom));
         end
      end
      item_total = pending_cmds.size();

      // Hold reset, then release it on a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Wait for every command to be taken and every result to come back,
      // then allow a few further cycles to catch any stray result.
      while (accepted_count < item_total) @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_matrix_3x3_arith_unit_top OK");
      end else begin
         $display("tb_matrix_3x3_arith_unit_top NOT OK");
      end
      $finish;
   end

endmodule
